@@ rtl/passive_aggressive_linear_learner_unit_macros.svh @@
// Assertion macros used by the learner back end
`ifndef PASSIVE_AGGRESSIVE_LINEAR_LEARNER_UNIT_MACROS_SVH
`define PASSIVE_AGGRESSIVE_LINEAR_LEARNER_UNIT_MACROS_SVH

// Check a property on every rising edge outside reset
`define PALL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle
`define PALL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/pall_pkg.sv @@
// Shared types, constants and helper functions of the learner
package pall_pkg;

  localparam int unsigned MaxIndexBits = 16;
  localparam int unsigned MaxFeatures  = 64;
  localparam int unsigned BufAw        = $clog2(MaxFeatures);
  localparam int unsigned CntW         = BufAw + 1;
  localparam int unsigned FifoDepth    = 4;
  localparam int unsigned FifoAw       = $clog2(FifoDepth);
  localparam int unsigned TableSize    = 1 << MaxIndexBits;

  typedef enum logic [1:0] {
    REQ_PREDICT  = 2'd0,
    REQ_TRAIN    = 2'd1,
    REQ_SUPPLIED = 2'd2,
    REQ_UNUSED   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    VAR_PA   = 2'd0,
    VAR_PA1  = 2'd1,
    VAR_PA2  = 2'd2,
    VAR_NONE = 2'd3
  } variant_e;

  typedef enum logic [1:0] {
    CFG_VARIANT = 2'd0,
    CFG_AGGR    = 2'd1,
    CFG_IBITS   = 2'd2,
    CFG_SPARE   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]              req;
    logic [MaxIndexBits-1:0] idx;
    logic signed [15:0]      val;
    logic signed [1:0]       lab;
    logic signed [31:0]      sup;
    logic                    last;
  } elem_t;

  typedef struct packed {
    logic [1:0]  variant;
    logic [31:0] aggr;
  } train_cfg_t;

  typedef struct packed {
    logic clearing;
    logic pop;
  } back_stat_t;

  // Keep the low index bits selected by the configured width, clamped to range
  function automatic logic [MaxIndexBits-1:0] mask_index(input logic [31:0] raw,
                                                         input logic [4:0]  nbits);
    logic [MaxIndexBits-1:0] m;
    logic [5:0]              b;
    b = {1'b0, nbits};
    if (b < 6'd1) b = 6'd1;
    if (b > 6'(MaxIndexBits)) b = 6'(MaxIndexBits);
    for (int k = 0; k < MaxIndexBits; k++) begin
      m[k] = (6'(k) < b);
    end
    return raw[MaxIndexBits-1:0] & m;
  endfunction

endpackage

@@ rtl/passive_aggressive_linear_learner_unit.sv @@
// Each item passes through the idle, multiply and accumulate states; a result follows its
//   last item through the finish state when no training happens.
// Training adds one division (two for PA2) plus a replay of each buffered item.
// The back end takes no new item while training or before the weight table read-multiply-accumulate loop ends.
// Reset: all control clears at once, then a sweep zeroes all 65536 weight table entries
//   with busy_o high; configuration writes are taken throughout. Results cannot be stalled.
module passive_aggressive_linear_learner_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         req_type_i,
  input  logic [31:0]        feature_index_i,
  input  logic signed [15:0] feature_value_i,
  input  logic signed [1:0]  label_i,
  input  logic signed [31:0] supplied_score_i,
  input  logic               last_feature_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output logic               result_valid_o,
  output logic signed [31:0] score_o,
  output logic               weights_updated_o,
  output logic               vector_overflow_o
);

  // front to queue to back
  logic                 push, fifo_empty, fifo_full;
  pall_pkg::elem_t      elem_in, elem_head;
  pall_pkg::train_cfg_t tcfg;
  pall_pkg::back_stat_t stat;

  // accept, mask the index and hold the configuration
  pall_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .req_type_i      (req_type_i),
    .feature_index_i (feature_index_i),
    .feature_value_i (feature_value_i),
    .label_i         (label_i),
    .supplied_score_i(supplied_score_i),
    .last_feature_i  (last_feature_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .fifo_full_i     (fifo_full),
    .stat_i          (stat),
    .push_o          (push),
    .elem_o          (elem_in),
    .tcfg_o          (tcfg)
  );

  // decouple acceptance from the accumulate and training engine
  pall_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .din_i  (elem_in),
    .pop_i  (stat.pop),
    .dout_o (elem_head),
    .empty_o(fifo_empty),
    .full_o (fifo_full)
  );

  // score, step size and weight replay
  pall_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .empty_i          (fifo_empty),
    .head_i           (elem_head),
    .tcfg_i           (tcfg),
    .stat_o           (stat),
    .result_valid_o   (result_valid_o),
    .score_o          (score_o),
    .weights_updated_o(weights_updated_o),
    .vector_overflow_o(vector_overflow_o)
  );

endmodule

@@ rtl/pall_front.sv @@
// Front end: configuration registers, item acceptance and index masking
module pall_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [1:0]           req_type_i,
  input  logic [31:0]          feature_index_i,
  input  logic signed [15:0]   feature_value_i,
  input  logic signed [1:0]    label_i,
  input  logic signed [31:0]   supplied_score_i,
  input  logic                 last_feature_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  input  logic                 fifo_full_i,
  input  pall_pkg::back_stat_t stat_i,
  output logic                 push_o,
  output pall_pkg::elem_t      elem_o,
  output pall_pkg::train_cfg_t tcfg_o
);

  logic [1:0]  variant_q;
  logic [31:0] aggr_q;
  logic [4:0]  ibits_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      variant_q <= pall_pkg::VAR_PA;
      aggr_q    <= 32'd65536;
      ibits_q   <= 5'd16;
    end else if (cfg_valid_i) begin
      case (pall_pkg::cfg_idx_e'(cfg_index_i))
        pall_pkg::CFG_VARIANT: variant_q <= cfg_data_i[1:0];
        pall_pkg::CFG_AGGR:    aggr_q    <= cfg_data_i;
        pall_pkg::CFG_IBITS:   ibits_q   <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  assign busy_o = fifo_full_i | stat_i.clearing;
  assign push_o = start_i & ~busy_o;

  always_comb begin
    elem_o.req  = req_type_i;
    elem_o.idx  = pall_pkg::mask_index(feature_index_i, ibits_q);
    elem_o.val  = feature_value_i;
    elem_o.lab  = label_i;
    elem_o.sup  = supplied_score_i;
    elem_o.last = last_feature_i;
  end

  assign tcfg_o.variant = variant_q;
  assign tcfg_o.aggr    = aggr_q;

endmodule

@@ rtl/pall_fifo.sv @@
// Short item queue between front and back
module pall_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pall_pkg::elem_t din_i,
  input  logic            pop_i,
  output pall_pkg::elem_t dout_o,
  output logic            empty_o,
  output logic            full_o
);

  pall_pkg::elem_t                mem_q [pall_pkg::FifoDepth];
  logic [pall_pkg::FifoAw-1:0]    wp_q, rp_q;
  logic [pall_pkg::FifoAw:0]      cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (pall_pkg::FifoAw+1)'(pall_pkg::FifoDepth));
  assign dout_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= din_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i)  rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (pall_pkg::FifoAw+1)'(push_i) - (pall_pkg::FifoAw+1)'(pop_i);
    end
  end

endmodule

@@ rtl/pall_div.sv @@
// Restoring divider, one quotient bit per cycle
module pall_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [63:0] quo_o
);

  logic [64:0] rem_q;
  logic [63:0] quo_q, den_q;
  logic [6:0]  cnt_q;
  logic        busy_q, done_q;
  logic [64:0] trial;
  logic        fits;

  assign trial = {rem_q[63:0], quo_q[63]};
  assign fits  = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= fits ? (trial - {1'b0, den_q}) : trial;
      quo_q <= {quo_q[62:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 7'd64;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

@@ rtl/pall_back.sv @@
// Back end: weight table, accumulation, step size and training replay
`include "passive_aggressive_linear_learner_unit_macros.svh"
module pall_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 empty_i,
  input  pall_pkg::elem_t      head_i,
  input  pall_pkg::train_cfg_t tcfg_i,
  output pall_pkg::back_stat_t stat_o,
  output logic                 result_valid_o,
  output logic signed [31:0]   score_o,
  output logic                 weights_updated_o,
  output logic                 vector_overflow_o
);

  typedef enum logic [10:0] {
    S_CLR  = 11'b000_0000_0001,
    S_IDLE = 11'b000_0000_0010,
    S_MUL  = 11'b000_0000_0100,
    S_ACC  = 11'b000_0000_1000,
    S_FIN  = 11'b000_0001_0000,
    S_DC   = 11'b000_0010_0000,
    S_DE   = 11'b000_0100_0000,
    S_RB   = 11'b000_1000_0000,
    S_RW   = 11'b001_0000_0000,
    S_RM   = 11'b010_0000_0000,
    S_RU   = 11'b100_0000_0000
  } state_e;

  localparam int unsigned Iw = pall_pkg::MaxIndexBits;
  localparam int unsigned Cw = pall_pkg::CntW;
  localparam logic signed [64:0] AccLim = 65'sh0_4000_0000_0000_0000;

  state_e state_q, state_d;

  // weight table and feature buffer
  logic [31:0]       wmem [pall_pkg::TableSize];
  logic [Iw+15:0]    bmem [pall_pkg::MaxFeatures];
  logic              w_we;
  logic [Iw-1:0]     w_waddr, w_raddr;
  logic [31:0]       w_wdata, w_rdata;
  logic [Iw+15:0]    b_rdata;

  logic [Iw:0]       clr_q;
  pall_pkg::elem_t   e_q;
  logic signed [63:0] acc_q;
  logic [39:0]       norm_q;
  logic [Cw-1:0]     cnt_q, ri_q;
  logic signed [47:0] prod_q;
  logic signed [31:0] sq_q;
  logic [63:0]       num_q;
  logic [31:0]       eta_q;
  logic signed [48:0] rprod_q;
  logic signed [31:0] wv_q;
  logic [Iw-1:0]     widx_q;
  logic signed [31:0] sc_q;
  logic              ovf_q;
  logic              res_valid_q, res_upd_q;

  logic              div_start, div_busy, div_done;
  logic [63:0]       div_num, div_den, div_quo;

  // combinational arithmetic
  logic signed [64:0] acc_sum;
  logic [40:0]        norm_sum;
  logic signed [63:0] sc_sh;
  logic signed [31:0] score32, basis;
  logic signed [34:0] lab_basis;
  logic signed [35:0] loss;
  logic               loss_pos, train_req, go;
  logic [40:0]        den2;
  logic [31:0]        eta_sat;
  logic signed [50:0] tdelta, dshift;
  logic signed [51:0] wsum;
  logic signed [31:0] wnew;
  logic signed [47:0] prod_d;
  logic signed [31:0] sq_d;
  logic signed [48:0] rprod_d;

  pall_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .busy_o (div_busy),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  always_comb begin
    prod_d  = $signed(w_rdata) * e_q.val;
    sq_d    = e_q.val * e_q.val;
    acc_sum = 65'(acc_q) + 65'(prod_q);
    norm_sum = 41'(norm_q) + 41'(sq_q[30:0]);
    sc_sh   = acc_q >>> 12;
    if (sc_sh > 64'sd2147483647)       score32 = 32'sh7FFF_FFFF;
    else if (sc_sh < -64'sd2147483648) score32 = 32'sh8000_0000;
    else                               score32 = sc_sh[31:0];
    basis     = (e_q.req == pall_pkg::REQ_SUPPLIED) ? e_q.sup : score32;
    lab_basis = 35'(e_q.lab) * 35'(basis);
    loss      = 36'sd65536 - 36'(lab_basis);
    loss_pos  = !loss[35] && (loss != '0);
    train_req = ((e_q.req == pall_pkg::REQ_TRAIN) || (e_q.req == pall_pkg::REQ_SUPPLIED))
                && (cnt_q <= Cw'(pall_pkg::MaxFeatures));
    go = train_req && loss_pos && (norm_q != '0) &&
         ((tcfg_i.variant == pall_pkg::VAR_PA) || (tcfg_i.variant == pall_pkg::VAR_PA1) ||
          ((tcfg_i.variant == pall_pkg::VAR_PA2) && (tcfg_i.aggr != '0)));
    den2    = 41'(norm_q) + div_quo[40:0];
    eta_sat = (div_quo[63:32] != '0) ? 32'hFFFF_FFFF : div_quo[31:0];
    if ((tcfg_i.variant == pall_pkg::VAR_PA1) && (eta_sat > tcfg_i.aggr)) eta_sat = tcfg_i.aggr;
    rprod_d = $signed({1'b0, eta_q}) * $signed(b_rdata[15:0]);
    case (e_q.lab)
      2'b10:   tdelta = -(51'(rprod_q) <<< 1);
      2'b11:   tdelta = -51'(rprod_q);
      2'b01:   tdelta = 51'(rprod_q);
      default: tdelta = '0;
    endcase
    dshift = tdelta >>> 12;
    wsum   = 52'(wv_q) + 52'(dshift);
    if (wsum > 52'sd2147483647)       wnew = 32'sh7FFF_FFFF;
    else if (wsum < -52'sd2147483648) wnew = 32'sh8000_0000;
    else                              wnew = wsum[31:0];
  end

  // memory ports
  always_comb begin
    w_we    = (state_q == S_CLR) || (state_q == S_RU);
    w_waddr = (state_q == S_CLR) ? clr_q[Iw-1:0] : widx_q;
    w_wdata = (state_q == S_CLR) ? '0 : wnew;
    w_raddr = (state_q == S_RW) ? b_rdata[Iw+15:16] : head_i.idx;
  end

  always_ff @(posedge clk_i) begin
    if (w_we) wmem[w_waddr] <= w_wdata;
    w_rdata <= wmem[w_raddr];
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_ACC) && (cnt_q < Cw'(pall_pkg::MaxFeatures)))
      bmem[cnt_q[Cw-2:0]] <= {e_q.idx, e_q.val};
    b_rdata <= bmem[ri_q[Cw-2:0]];
  end

  // divider requests
  always_comb begin
    div_start = 1'b0;
    div_num   = num_q;
    div_den   = 64'(norm_q);
    if ((state_q == S_FIN) && go) begin
      div_start = 1'b1;
      div_num   = 64'({loss[34:0], 24'd0});
      if (tcfg_i.variant == pall_pkg::VAR_PA2) begin
        div_num = 64'd1 << 39;
        div_den = 64'(tcfg_i.aggr);
      end
    end else if ((state_q == S_DC) && div_done) begin
      div_start = 1'b1;
      div_den   = 64'(den2);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLR:  if (clr_q == (Iw+1)'(pall_pkg::TableSize - 1)) state_d = S_IDLE;
      S_IDLE: if (!empty_i) state_d = S_MUL;
      S_MUL:  state_d = S_ACC;
      S_ACC:  state_d = e_q.last ? S_FIN : S_IDLE;
      S_FIN: begin
        if (!go) state_d = S_IDLE;
        else if (tcfg_i.variant == pall_pkg::VAR_PA2) state_d = S_DC;
        else state_d = S_DE;
      end
      S_DC:   if (div_done) state_d = S_DE;
      S_DE:   if (div_done) state_d = S_RB;
      S_RB:   state_d = S_RW;
      S_RW:   state_d = S_RM;
      S_RM:   state_d = S_RU;
      S_RU:   state_d = (ri_q + 1'b1 == cnt_q) ? S_IDLE : S_RB;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      acc_q       <= '0;
      norm_q      <= '0;
      cnt_q       <= '0;
      ri_q        <= '0;
      res_valid_q <= 1'b0;
      res_upd_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= 1'b0;
      case (state_q)
        S_CLR: clr_q <= clr_q + 1'b1;
        S_ACC: begin
          if (acc_sum > AccLim)       acc_q <= AccLim[63:0];
          else if (acc_sum < -AccLim) acc_q <= -AccLim[63:0];
          else                        acc_q <= acc_sum[63:0];
          norm_q <= norm_sum[40] ? 40'hFF_FFFF_FFFF : norm_sum[39:0];
          if (cnt_q <= Cw'(pall_pkg::MaxFeatures)) cnt_q <= cnt_q + 1'b1;
        end
        S_FIN: begin
          ri_q <= '0;
          if (!go) begin
            res_valid_q <= 1'b1;
            res_upd_q   <= 1'b0;
            acc_q <= '0; norm_q <= '0; cnt_q <= '0;
          end
        end
        S_RU: begin
          ri_q <= ri_q + 1'b1;
          if (ri_q + 1'b1 == cnt_q) begin
            res_valid_q <= 1'b1;
            res_upd_q   <= 1'b1;
            acc_q <= '0; norm_q <= '0; cnt_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if ((state_q == S_IDLE) && !empty_i) e_q <= head_i;
    if (state_q == S_MUL) begin
      prod_q <= prod_d;
      sq_q   <= sq_d;
    end
    if (state_q == S_FIN) begin
      sc_q  <= score32;
      ovf_q <= (cnt_q > Cw'(pall_pkg::MaxFeatures));
      num_q <= 64'({loss[34:0], 24'd0});
    end
    if ((state_q == S_DE) && div_done) eta_q <= eta_sat;
    if (state_q == S_RW) widx_q <= b_rdata[Iw+15:16];
    if (state_q == S_RM) begin
      rprod_q <= rprod_d;
      wv_q    <= $signed(w_rdata);
    end
  end

  assign stat_o.clearing   = (state_q == S_CLR);
  assign stat_o.pop        = (state_q == S_IDLE) && !empty_i;
  assign result_valid_o    = res_valid_q;
  assign score_o           = sc_q;
  assign weights_updated_o = res_upd_q;
  assign vector_overflow_o = ovf_q;

  `PALL_ASSERT_IMP(a_we_ctx, w_we, (state_q == S_CLR) || (state_q == S_RU), "stray weight write")
  `PALL_ASSERT_IMP(a_div_idle, div_start, !div_busy, "divider restarted while busy")
  `PALL_ASSERT(a_res_src, !res_valid_q || ($past(state_q) == S_FIN) || ($past(state_q) == S_RU), "result without finish")

endmodule
